// ===== rtl/sptk_pkg.sv =====
// Shared types, sizes and codes for the sustain pedal key tracker.
`timescale 1ns / 1ps

package sptk_pkg;

  localparam int NUM_KEYS  = 128;
  localparam int KEY_AW    = $clog2(NUM_KEYS);
  localparam int SWEEP_W   = $clog2(NUM_KEYS + 1);
  localparam int CNT_W     = $clog2(NUM_KEYS + 1);
  localparam int PITCH_W   = 7;
  localparam int VEL_W     = 7;
  localparam int PRESSED_W = 8;

  typedef enum logic [1:0] {
    OP_NOTE       = 2'd0,
    OP_PEDAL      = 2'd1,
    OP_READ       = 2'd2,
    OP_READ_DECAY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    op_e                operation;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic               pedal_down;
    logic               decay_tick;
  } item_t;

  typedef struct packed {
    logic [VEL_W-1:0]     read_velocity;
    logic [PITCH_W-1:0]   low_key;
    logic [PITCH_W-1:0]   last_key;
    logic [PRESSED_W-1:0] pressed_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic sweep_read;
    logic sweep_write;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_sweep;
    logic sweep_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/sptk_ctrl.sv =====
// Sequencer for the key tracker: accept, execute, release sweep, commit.
`timescale 1ns / 1ps

module sptk_ctrl import sptk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.needs_sweep) begin
          cmd_o.sweep_read = 1'b1;
          state_d          = ST_SWEEP;
        end else if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        // write back the key read last cycle, fetch the next one
        cmd_o.sweep_write = 1'b1;
        if (!status_i.sweep_done) begin
          cmd_o.sweep_read = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sptk_datapath.sv =====
// Key stores, tracking registers, sweep counter and result register.
`timescale 1ns / 1ps

module sptk_datapath import sptk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      in_item_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output result_t    out_item_o
);

  logic [VEL_W-1:0] raw_mem  [NUM_KEYS];
  logic [VEL_W-1:0] sus_mem  [NUM_KEYS];
  logic [VEL_W-1:0] disp_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] valid_q;

  item_t              item_q;
  logic [KEY_AW-1:0]  rd_idx_q;
  logic [VEL_W-1:0]   raw_rd_q, sus_rd_q, disp_rd_q, sus_bass_q;
  logic               valid_rd_q, valid_bass_q;
  logic [SWEEP_W-1:0] sweep_idx_q;

  logic               held_q, held_d;
  logic [PITCH_W-1:0] lowest_note_q, lowest_note_d;
  logic [PITCH_W-1:0] recent_key_q, recent_key_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q;
  result_t            out_item_q;

  logic               rd_en;
  logic [KEY_AW-1:0]  rd_addr, key_idx, bass_idx, wr_addr;
  logic               raw_we, sus_we, disp_we, set_valid;
  logic [VEL_W-1:0]   sus_wd, disp_wd;
  logic               pitch_ok, lowest_ok, bass_silent;
  logic [VEL_W-1:0]   sus_old, disp_old, sus_new, disp_new, rd_vel;
  logic [PRESSED_W-1:0] pressed;

  assign rd_en    = cmd_i.load | cmd_i.sweep_read;
  assign rd_addr  = cmd_i.sweep_read ? sweep_idx_q[KEY_AW-1:0] : KEY_AW'(in_item_i.pitch);
  assign key_idx  = KEY_AW'(item_q.pitch);
  assign bass_idx = KEY_AW'(lowest_note_q);

  // Stores: one write port each, registered reads
  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[wr_addr] <= item_q.velocity;
    end
    if (rd_en) begin
      raw_rd_q <= raw_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sus_we) begin
      sus_mem[wr_addr] <= sus_wd;
    end
    if (rd_en) begin
      sus_rd_q <= sus_mem[rd_addr];
    end
    if (cmd_i.load) begin
      sus_bass_q <= sus_mem[bass_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (disp_we) begin
      disp_mem[wr_addr] <= disp_wd;
    end
    if (rd_en) begin
      disp_rd_q <= disp_mem[rd_addr];
    end
  end

  // Payload latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q       <= in_item_i;
      valid_bass_q <= valid_q[bass_idx];
    end
    if (rd_en) begin
      rd_idx_q   <= rd_addr;
      valid_rd_q <= valid_q[rd_addr];
    end
  end

  assign pitch_ok  = int'(item_q.pitch) < NUM_KEYS;
  assign lowest_ok = int'(lowest_note_q) < NUM_KEYS;
  assign sus_old   = valid_rd_q ? sus_rd_q : '0;
  assign disp_old  = valid_rd_q ? disp_rd_q : '0;
  assign sus_new   = (held_q && (item_q.velocity == '0)) ? sus_old : item_q.velocity;
  assign disp_new  = (item_q.decay_tick && (disp_old != '0)) ? disp_old - VEL_W'(1) : disp_old;

  // Bass silent? When the key being written is the bass key, its new sustained value decides, else its stored one
  always_comb begin
    if (!lowest_ok) begin
      bass_silent = 1'b1;
    end else if (lowest_note_q == item_q.pitch) begin
      bass_silent = (sus_new == '0);
    end else begin
      bass_silent = !(valid_bass_q && (sus_bass_q != '0));
    end
  end

  always_comb begin
    raw_we        = 1'b0;
    sus_we        = 1'b0;
    disp_we       = 1'b0;
    set_valid     = 1'b0;
    wr_addr       = key_idx;
    sus_wd        = sus_new;
    disp_wd       = sus_new;
    count_d       = count_q;
    lowest_note_d = lowest_note_q;
    recent_key_d  = recent_key_q;
    held_d        = held_q;
    rd_vel        = '0;
    if (cmd_i.sweep_write) begin
      wr_addr = rd_idx_q;
      // drop sustain on keys that are no longer held down
      if (valid_rd_q && (raw_rd_q == '0)) begin
        sus_we  = 1'b1;
        disp_we = 1'b1;
        sus_wd  = '0;
        disp_wd = '0;
        if (sus_rd_q != '0) begin
          count_d = count_q - CNT_W'(1);
        end
      end
    end
    if (cmd_i.commit) begin
      case (item_q.operation)
        OP_NOTE: begin
          if (pitch_ok) begin
            raw_we    = 1'b1;
            sus_we    = 1'b1;
            disp_we   = 1'b1;
            set_valid = 1'b1;
            count_d   = count_q + CNT_W'(sus_new != '0) - CNT_W'(sus_old != '0);
            if ((sus_new != '0) && (bass_silent || (item_q.pitch < lowest_note_q))) begin
              lowest_note_d = item_q.pitch;
            end
            recent_key_d = item_q.pitch;
          end
        end
        OP_PEDAL: begin
          held_d = item_q.pedal_down;
        end
        OP_READ: begin
          if (pitch_ok) begin
            rd_vel = sus_old;
          end
        end
        OP_READ_DECAY: begin
          if (pitch_ok) begin
            rd_vel = disp_new;
            if (valid_rd_q) begin
              disp_we = 1'b1;
              disp_wd = disp_new;
            end
          end
        end
        default: begin
          rd_vel = '0;
        end
      endcase
    end
  end

  assign pressed = (int'(count_d) > int'({PRESSED_W{1'b1}})) ? {PRESSED_W{1'b1}}
                                                              : PRESSED_W'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      sweep_idx_q   <= '0;
      held_q        <= 1'b0;
      lowest_note_q <= '0;
      recent_key_q  <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (set_valid) begin
        valid_q[key_idx] <= 1'b1;
      end
      if (cmd_i.load) begin
        sweep_idx_q <= '0;
      end else if (cmd_i.sweep_read) begin
        sweep_idx_q <= sweep_idx_q + SWEEP_W'(1);
      end
      held_q        <= held_d;
      lowest_note_q <= lowest_note_d;
      recent_key_q  <= recent_key_d;
      count_q       <= count_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_item_q <= '{read_velocity: rd_vel, low_key: lowest_note_d,
                      last_key: recent_key_d, pressed_count: pressed};
    end
  end

  assign status_o.needs_sweep = (item_q.operation == OP_PEDAL) && !item_q.pedal_down && held_q;
  assign status_o.sweep_done  = (sweep_idx_q == SWEEP_W'(NUM_KEYS));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/sustain_pedal_key_tracker_unit.sv =====
// Top level of the sustain pedal key tracker.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------
//   input   | in        | in_valid_i / in_stall_o  | in_item_i  item_t
//   result  | out       | out_valid_o / out_stall_i| out_item_o result_t
//
// Note events, reads and pedal presses are accepted in the idle state, which
// also reads the key stores; the execute state then updates them and loads
// the result register once free. A pedal release while held adds a sweep of
// all NUM_KEYS keys, one key per cycle through the store read and write ports.
// Reset clears every key at once through per-key valid bits; no clearing pass.
// A stalled result holds in the output register while the next item is taken;
// the block waits only when a new result meets a stalled one in that register.
`timescale 1ns / 1ps

module sustain_pedal_key_tracker_unit import sptk_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_item_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sptk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sptk_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/sptk_checker.sv =====
// Port-level checks for the key tracker, bound to the top level.
`timescale 1ns / 1ps

module sptk_checker import sptk_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input item_t   in_item_i,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input result_t out_item_o
);

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // a stalled input transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input changed");

  // one item at a time: busy right after an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  // a new result only follows a cycle spent working on an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in progress");

  // the pressed count never exceeds the keyboard size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_item_o.pressed_count) <= NUM_KEYS))
    else $error("pressed count beyond key count");

endmodule

bind sustain_pedal_key_tracker_unit sptk_checker u_sptk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
